// ----- hdl/xcfc_pkg.sv -----
// Shared types, codes and constants for the XOR-checked frame checker.
`default_nettype none

package xcfc_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  // Result item packed into whole bytes
  localparam int unsigned ResW     = StatusW + ByteW + ByteW + LenW;
  localparam int unsigned ResBytesW = ((ResW + 7) / 8) * 8;

  // Frame constants
  localparam logic [ByteW-1:0] StartCode   = 8'hAA;
  localparam logic [ByteW-1:0] EndCode     = 8'h55;
  localparam logic [LenW-1:0]  MinLength   = 16'd13;
  localparam logic [ByteW-1:0] CmdText     = 8'd5;
  localparam logic [ByteW-1:0] CmdUpload   = 8'd6;
  localparam logic [LenW-1:0]  PosMsgId    = 16'd9;
  localparam logic [LenW-1:0]  PosCmdType  = 16'd10;
  localparam logic [LenW-1:0]  PosLenHigh  = 16'd1;
  localparam logic [LenW-1:0]  PosLenLow   = 16'd2;
  localparam logic [LenW-1:0]  PosPayload  = 16'd3;

  // Configuration reset values
  localparam logic [LenW-1:0] MaxLengthRst = 16'd276;
  localparam logic            CheckCmdRst  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxLength = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCheckCmd  = 8'd1;

  // Frame phase codes
  localparam logic [1:0] PhaseHunt  = 2'd0;
  localparam logic [1:0] PhaseFrame = 2'd1;

  // Status codes
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadLen   = 3'd1;
  localparam logic [StatusW-1:0] StBadEnd   = 3'd2;
  localparam logic [StatusW-1:0] StBadSum   = 3'd3;
  localparam logic [StatusW-1:0] StBadCmd   = 3'd4;

  // Configuration values seen by the parser
  typedef struct packed {
    logic [LenW-1:0] max_length;
    logic            check_command_type;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [LenW-1:0]    frame_length;
    logic [ByteW-1:0]   command_type;
    logic [ByteW-1:0]   message_id;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/xor_checked_frame_checker.sv -----
// Top level of the XOR-checked frame checker.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   status, message_id, command_type, frame_length
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One byte per cycle while the output register is not stalled: a byte is taken
// into the input register and parsed from there; if it closes a frame or fails
// the length check, its result is loaded into the output register at the end
// of the cycle in which the byte is parsed.
// A stalled output register holds the input register; the input side keeps
// taking bytes whenever its register is empty or moving on.
// Reset clears the parser to hunting and loads register reset values.
// The configuration port is always ready.
`default_nettype none

module xor_checked_frame_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [xcfc_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] rx_byte
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [2:0] status, [10:3] message_id, [18:11] command_type,
  // [34:19] frame_length, [39:35] zero
  output      logic [xcfc_pkg::ResBytesW-1:0] m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [xcfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [xcfc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import xcfc_pkg::*;

  cfg_t             cfg;
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;
  logic             step;
  logic             res_valid;
  res_t             res;
  logic             in_frame;
  logic             out_vld_q;
  res_t             out_q;

  assign cfg_ready_o = 1'b1;

  xcfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the pipeline when the output register is free or being drained
  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = advance && in_vld_q;
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  xcfc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .in_frame_o  (in_frame)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(ResBytesW-ResW){1'b0}}, out_q};

  // A bad-length result never carries captured header bytes
  a_badlen_no_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status == StBadLen) |->
      (out_q.message_id == '0 && out_q.command_type == '0))
    else $error("bad-length result carries header bytes");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.status <= StBadCmd))
    else $error("result status out of range");

  // Every reported frame leaves the parser hunting
  a_hunt_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid) |=> !in_frame)
    else $error("parser still in frame after result");

  // A processed byte that yields a result lands in the output register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid) |=> out_vld_q)
    else $error("result lost");

endmodule

`default_nettype wire

// ----- hdl/xcfc_cfg_regs.sv -----
// Configuration registers of the frame checker.
`default_nettype none

module xcfc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [xcfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [xcfc_pkg::CfgDataW-1:0] cfg_data_i,
  output      xcfc_pkg::cfg_t                cfg_o
);
  import xcfc_pkg::*;

  logic [LenW-1:0] max_length_q;
  logic            check_cmd_q;

  // Decode writes; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthRst;
      check_cmd_q  <= CheckCmdRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxLength: max_length_q <= cfg_data_i[LenW-1:0];
        RegCheckCmd:  check_cmd_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.max_length         = max_length_q;
  assign cfg_o.check_command_type = check_cmd_q;

endmodule

`default_nettype wire

// ----- hdl/xcfc_parse.sv -----
// Frame parser: position counter, running XOR, header capture and status.
`default_nettype none

module xcfc_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [xcfc_pkg::ByteW-1:0] rx_byte_i,
  input       xcfc_pkg::cfg_t             cfg_i,
  output      logic                       res_valid_o,
  output      xcfc_pkg::res_t             res_o,
  output      logic                       in_frame_o
);
  import xcfc_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic             cm_q, cm_d;
  logic [ByteW-1:0] mid_q, mid_d;
  logic [ByteW-1:0] ct_q, ct_d;

  logic [LenW:0]    pos_plus2;
  logic [LenW-1:0]  len_low;
  logic             cmd_ok;

  assign pos_plus2 = {1'b0, pos_q} + {{LenW{1'b0}}, 1'b0} + (LenW+1)'(2);
  assign len_low   = {len_q[LenW-1:ByteW], rx_byte_i};
  assign cmd_ok    = !cfg_i.check_command_type || (ct_q == CmdText) ||
                     (ct_q == CmdUpload);

  // Work out next state and any result for the current byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    len_d       = len_q;
    xor_d       = xor_q;
    cm_d        = cm_q;
    mid_d       = mid_q;
    ct_d        = ct_q;
    res_valid_o = 1'b0;
    res_o       = '{frame_length: len_q, command_type: ct_q,
                    message_id: mid_q, status: StOk};

    if (phase_q != PhaseFrame) begin
      // Hunt for the start code
      if (rx_byte_i == StartCode) begin
        phase_d = PhaseFrame;
        pos_d   = PosLenHigh;
        xor_d   = rx_byte_i;
        cm_d    = 1'b0;
        mid_d   = '0;
        ct_d    = '0;
        len_d   = '0;
      end
    end else if (pos_q == PosLenHigh) begin
      len_d = {rx_byte_i, {ByteW{1'b0}}};
      xor_d = xor_q ^ rx_byte_i;
      pos_d = PosLenLow;
    end else if (pos_q == PosLenLow) begin
      len_d = len_low;
      xor_d = xor_q ^ rx_byte_i;
      pos_d = PosPayload;
      // Reject a bad length at once and hunt again
      if ((len_low < MinLength) || (len_low > cfg_i.max_length)) begin
        res_valid_o = 1'b1;
        res_o       = '{frame_length: len_low, command_type: '0,
                        message_id: '0, status: StBadLen};
        phase_d     = PhaseHunt;
        pos_d       = '0;
        xor_d       = '0;
        cm_d        = 1'b0;
      end
    end else begin
      if (pos_q == PosMsgId)   mid_d = rx_byte_i;
      if (pos_q == PosCmdType) ct_d  = rx_byte_i;

      if (pos_plus2 < {1'b0, len_q}) begin
        xor_d = xor_q ^ rx_byte_i;
        pos_d = pos_q + LenW'(1);
      end else if (pos_plus2 == {1'b0, len_q}) begin
        // Checksum byte
        cm_d  = (rx_byte_i == xor_q);
        pos_d = pos_q + LenW'(1);
      end else begin
        // End code byte: report first failing check
        res_valid_o = 1'b1;
        if (rx_byte_i != EndCode)  res_o.status = StBadEnd;
        else if (!cm_q)            res_o.status = StBadSum;
        else if (!cmd_ok)          res_o.status = StBadCmd;
        else                       res_o.status = StOk;
        phase_d = PhaseHunt;
        pos_d   = '0;
        xor_d   = '0;
        cm_d    = 1'b0;
      end
    end
  end

  // Advance state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseHunt;
      pos_q   <= '0;
      len_q   <= '0;
      xor_q   <= '0;
      cm_q    <= 1'b0;
      mid_q   <= '0;
      ct_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      cm_q    <= cm_d;
      mid_q   <= mid_d;
      ct_q    <= ct_d;
    end
  end

  assign in_frame_o = (phase_q == PhaseFrame);

endmodule

`default_nettype wire

// ----- sim/xcfc_status_checker.sv -----
// Frame status checker: predicts each frame result from accepted bytes and compares.
module xcfc_status_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid_i,
  input  wire logic                           s_tready_i,
  input  wire logic [xcfc_pkg::ByteW-1:0]     s_tdata_i,    // [7:0] rx_byte
  input  wire logic                           m_tvalid_i,
  input  wire logic                           m_tready_i,
  // [2:0] status, [10:3] message_id, [18:11] command_type, [34:19] frame_length
  input  wire logic [xcfc_pkg::ResBytesW-1:0] m_tdata_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [xcfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [xcfc_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o
);
  import xcfc_pkg::*;

  // Register copies
  logic [LenW-1:0]  max_len_q;
  logic             chk_cmd_q;

  // Parser copy
  logic [1:0]       phase_q;
  logic [LenW-1:0]  pos_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] xor_q;
  logic             sum_ok_q;
  logic [ByteW-1:0] id_q;
  logic [ByteW-1:0] cmd_q;

  // Frame results still owed by the block, oldest first
  res_t frame_status_q[$];
  res_t seen_res;
  res_t owed_res;
  res_t new_res;

  function automatic void restart_hunt();
    phase_q  = PhaseHunt;
    pos_q    = '0;
    xor_q    = '0;
    sum_ok_q = 1'b0;
  endfunction

  // Advance the parser copy by one byte; return 1 when the byte closes a frame or fails the length check
  function automatic bit parse_rx_byte(input logic [ByteW-1:0] b, output res_t r);
    r = '0;
    if (phase_q != PhaseFrame) begin
      if (b == StartCode) begin
        phase_q  = PhaseFrame;
        pos_q    = PosLenHigh;
        xor_q    = b;
        sum_ok_q = 1'b0;
        id_q     = '0;
        cmd_q    = '0;
        len_q    = '0;
      end
      return 1'b0;
    end
    if (pos_q == PosLenHigh) begin
      len_q = {b, 8'h00};
      xor_q ^= b;
      pos_q = PosLenLow;
      return 1'b0;
    end
    if (pos_q == PosLenLow) begin
      len_q[7:0] = b;
      xor_q ^= b;
      // Bound check happens right after the size field
      if (len_q < MinLength || len_q > max_len_q) begin
        r.status       = StBadLen;
        r.frame_length = len_q;
        restart_hunt();
        return 1'b1;
      end
      pos_q = PosPayload;
      return 1'b0;
    end
    if (pos_q == PosMsgId) id_q = b;
    if (pos_q == PosCmdType) cmd_q = b;
    if (int'(pos_q) + 2 < int'(len_q)) begin
      xor_q ^= b;
      pos_q = pos_q + 1'b1;
      return 1'b0;
    end
    if (int'(pos_q) + 2 == int'(len_q)) begin
      sum_ok_q = (b == xor_q);
      pos_q = pos_q + 1'b1;
      return 1'b0;
    end
    // Last byte: end code first, then checksum, then command type
    if (b != EndCode) r.status = StBadEnd;
    else if (!sum_ok_q) r.status = StBadSum;
    else if (chk_cmd_q && cmd_q != CmdText && cmd_q != CmdUpload) r.status = StBadCmd;
    else r.status = StOk;
    r.message_id   = id_q;
    r.command_type = cmd_q;
    r.frame_length = len_q;
    restart_hunt();
    return 1'b1;
  endfunction

  function automatic int field_differs(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q = MaxLengthRst;
      chk_cmd_q = CheckCmdRst;
      restart_hunt();
      len_q     = '0;
      id_q      = '0;
      cmd_q     = '0;
      frame_status_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Compare a delivered result with the oldest owed one
      if (m_tvalid_i && m_tready_i) begin
        seen_res = res_t'(m_tdata_i[ResW-1:0]);
        if (frame_status_q.size() == 0) begin
          $error("unexpected result item: status %0d, length %0d",
                 seen_res.status, seen_res.frame_length);
          mismatch_count_o++;
        end else begin
          owed_res = frame_status_q.pop_front();
          mismatch_count_o += field_differs("status", owed_res.status, seen_res.status);
          mismatch_count_o += field_differs("message_id", owed_res.message_id,
                                            seen_res.message_id);
          mismatch_count_o += field_differs("command_type", owed_res.command_type,
                                            seen_res.command_type);
          mismatch_count_o += field_differs("frame_length", owed_res.frame_length,
                                            seen_res.frame_length);
        end
      end
      // Track register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegMaxLength: max_len_q = cfg_data_i;
          RegCheckCmd:  chk_cmd_q = cfg_data_i[0];
          default: ;
        endcase
      end
      // Predict from the accepted byte
      if (s_tvalid_i && s_tready_i) begin
        if (parse_rx_byte(s_tdata_i, new_res)) frame_status_q.push_back(new_res);
      end
      pending_o = frame_status_q.size();
    end
  end

endmodule

// ----- sim/xor_checked_frame_checker_tb.sv -----
// Testbench top: drives byte frames and register writes, and reports the verdict.
module xor_checked_frame_checker_tb;
  import xcfc_pkg::*;

  localparam int ClkPeriod      = 12;
  localparam int TimeoutCycles  = 400000;
  localparam int DrainCycles    = 6;
  localparam int LongHoldCycles = 300;
  localparam int RandItems      = 800;
  localparam int NumPhases      = 6;
  localparam int ShortFrameMax  = 60;
  localparam int LongFrameMax   = 300;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic [ByteW-1:0]     s_tdata   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  wire logic            s_tready;
  wire logic            m_tvalid;
  wire logic [ResBytesW-1:0] m_tdata;
  wire logic            cfg_ready;
  int                   mismatch_count;
  int                   pending;

  // Shared pacing controls
  bit                   quiet          = 1'b0;
  bit                   long_hold_req  = 1'b0;
  bit                   long_hold_taken = 1'b0;

  // Settings the stimulus assumes, and a byte count for frame traffic
  logic [LenW-1:0]      cur_max = MaxLengthRst;
  int                   frame_bytes_sent = 0;

  logic [LenW-1:0] phase_max [NumPhases] = '{16'd276, 16'd13, 16'hFFFF, 16'd40, 16'd300, 16'd128};
  bit              phase_chk [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  bit              phase_quiet [NumPhases] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  xor_checked_frame_checker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  xcfc_status_checker status_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, maybe after a gap, and hold it until taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
  endtask

  // Drop valid, wait for all owed results, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers plus one unknown index in a single valid burst
  task automatic set_config(input logic [LenW-1:0] max_len, input logic chk);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= RegMaxLength;
    cfg_data  <= max_len;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CfgIdxW'($urandom_range(RegCheckCmd + 1, 255));
    cfg_data  <= CfgDataW'($urandom);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= RegCheckCmd;
    cfg_data  <= {15'($urandom), chk};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_max = max_len;
  endtask

  // Build and send a frame; a bad length sends the header only, keep > 0 truncates
  task automatic send_frame(input logic [LenW-1:0] len, input logic [ByteW-1:0] id,
                            input logic [ByteW-1:0] cmd, input bit bad_sum,
                            input bit bad_end, input int keep);
    logic [ByteW-1:0] frame_q[$];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] tail;
    frame_q = {StartCode, len[15:8], len[7:0]};
    if (len >= MinLength && len <= cur_max) begin
      for (int p = PosPayload; p < int'(len) - 2; p++) begin
        if (p == PosMsgId) frame_q.push_back(id);
        else if (p == PosCmdType) frame_q.push_back(cmd);
        else frame_q.push_back(ByteW'($urandom));
      end
      sum = '0;
      foreach (frame_q[i]) sum ^= frame_q[i];
      if (bad_sum) sum ^= ByteW'($urandom_range(1, 255));
      frame_q.push_back(sum);
      tail = EndCode;
      if (bad_end) begin
        tail = ByteW'($urandom);
        if (tail == EndCode) tail = ~tail;
      end
      frame_q.push_back(tail);
    end
    if (keep > 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_bytes_sent += frame_q.size();
  endtask

  // One random unit: mostly well-formed frames, some bad headers, noise and cut frames
  task automatic random_item();
    int pick;
    int hi;
    int n;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] nb;
    pick = $urandom_range(0, 99);
    hi   = (cur_max > ShortFrameMax) ? ShortFrameMax : int'(cur_max);
    len  = LenW'($urandom_range(MinLength, hi));
    if ($urandom_range(0, 9) == 0)
      len = LenW'($urandom_range(MinLength, (cur_max > LongFrameMax) ? LongFrameMax : cur_max));
    n = $urandom_range(0, 9);
    cmd = (n < 4) ? CmdText : (n < 7) ? CmdUpload : ByteW'($urandom);
    if (pick < 72) begin
      send_frame(len, ByteW'($urandom), cmd, $urandom_range(0, 9) == 0,
                 $urandom_range(0, 11) == 0, 0);
    end else if (pick < 82) begin
      case ($urandom_range(0, 2))
        0: len = LenW'($urandom_range(0, MinLength - 1));
        1: len = (cur_max == '1) ? LenW'($urandom_range(0, MinLength - 1)) : cur_max + 1'b1;
        default: len = LenW'($urandom);
      endcase
      if (len >= MinLength && len <= cur_max) len = '0;
      send_frame(len, ByteW'($urandom), cmd, 1'b0, 1'b0, 0);
    end else if (pick < 92) begin
      // Keep stray start codes out when a bogus length could swallow the run
      n = $urandom_range(1, 6);
      repeat (n) begin
        nb = ByteW'($urandom);
        if (nb == StartCode && cur_max > LongFrameMax) nb = ~nb;
        send_byte(nb);
      end
    end else begin
      send_frame(len, ByteW'($urandom), cmd, 1'b0, 1'b0,
                 $urandom_range(PosPayload, int'(len) - 1));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none when quiet
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left = idle_len() - 1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: hunting noise, size bounds, each status, check order
    quiet = 1'b1;
    set_config(MaxLengthRst, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(EndCode);
    send_frame(MinLength, 8'h00, CmdText, 1'b0, 1'b0, 0);
    send_frame(MaxLengthRst, 8'hFF, CmdUpload, 1'b0, 1'b0, 0);
    send_frame(MaxLengthRst + 1'b1, 8'h11, CmdText, 1'b0, 1'b0, 0);
    send_frame(MinLength - 1'b1, 8'h22, CmdText, 1'b0, 1'b0, 0);
    send_frame('0, 8'h33, CmdText, 1'b0, 1'b0, 0);
    send_frame(16'd20, StartCode, 8'hFF, 1'b0, 1'b0, 0);
    send_frame(16'd20, 8'h5A, CmdText, 1'b0, 1'b1, 0);
    send_frame(16'd20, 8'hA5, CmdUpload, 1'b1, 1'b0, 0);
    send_frame(16'd20, 8'h01, 8'h07, 1'b1, 1'b1, 0);
    send_frame(16'd20, 8'h80, 8'h07, 1'b1, 1'b0, 0);
    set_config(16'hFFFE, 1'b0);
    send_frame(16'hFFFF, 8'h44, CmdText, 1'b0, 1'b0, 0);
    send_frame(16'd24, 8'h7F, 8'h00, 1'b0, 1'b0, 0);
    set_config(MinLength, 1'b1);
    send_frame(MinLength, 8'hC3, CmdUpload, 1'b0, 1'b0, 0);
    send_frame(MinLength + 1'b1, 8'h3C, CmdUpload, 1'b0, 1'b0, 0);

    // Random phases, each under its own register setting
    base = frame_bytes_sent;
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_config(phase_max[ph], phase_chk[ph]);
      quiet = phase_quiet[ph];
      if (ph == 0) long_hold_req = 1'b1;
      while (frame_bytes_sent < base + RandItems * (ph + 1) / NumPhases) random_item();
    end

    wait_drained();
    if (mismatch_count == 0 && pending == 0) begin
      $display("xor_checked_frame_checker_tb: PASS");
    end else begin
      $display("xor_checked_frame_checker_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("xor_checked_frame_checker_tb: FAIL");
    $finish;
  end

endmodule
